// ===== rtl/core/sem_pkg.sv =====
// Shared types and constants for the RGBA Sobel edge magnitude block.
// Used by the top level, the line store RAM instances and the port checker.
package sem_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 32;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;

  // register byte offset bit (registers at 0 and 4)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       flush;
  } in_t;

  typedef struct packed {
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic [7:0] alpha_out;
    logic       frame_last;
  } out_t;

endpackage

// ===== rtl/core/sobel_edge_magnitude_rgba_top.sv =====
// RGBA Sobel edge magnitude, top level: sequencer, window and datapath.
// Depends on sem_pkg and two sem_ram line stores.
//
// Usage:
// - in_valid/in_stall/in_data carry one pixel (or flush marker) per
//   transaction in raster order; out_valid/out_stall/out_data carry results.
// - Registers via APB: image_width at 0x0, image_height at 0x4. Any write
//   restarts the frame (counters and window cleared, line stores kept).
// - The result for pixel p leaves on input item p+W+1; after W*H pixels send
//   W+1 flush items. The final result carries frame_last and the counters
//   restart. Flush items before the frame's pixels are done are dropped.
// - Flow: the block takes no new item until it is back in idle. An item that
//   produces a result passes the line store read-modify-write, the gradient
//   and squaring stages, the 8-step bit-serial square root and the output
//   load, then the idle state in which the next item is taken; one that does
//   not passes only the read-modify-write, and a dropped flush only idle.
// - Reset (rst_n low, synchronous) restores the register defaults (640x480),
//   clears counters, window and the output valid. Line stores are not
//   cleared; their stale entries never reach a result.
// - When out_stall is high the result holds; one further item that produces a
//   result can be taken and processed, then the block waits with in_stall high
//   until the output register frees.
module sobel_edge_magnitude_rgba_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sem_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sem_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_GRAD = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [11:0]            width_r;
  logic [15:0]            height_r;
  logic [27:0]            total_r;
  logic [10:0]            col_r;
  logic [16:0]            row_r;
  logic [27:0]            emit_r;
  sem_pkg::pix_t          win_r [3][3];
  sem_pkg::pix_t          pix_r;
  logic [sem_pkg::ADDR_W-1:0] addr_r;
  logic                   lsel_r, rsel_r, last_r;
  logic [7:0]             alpha_r;
  logic signed [11:0]     gx_r [3];
  logic signed [11:0]     gy_r [3];
  logic [15:0]            sq_r [3];
  logic                   sat_r [3];
  logic [7:0]             root_r [3];
  logic [2:0]             bit_r;
  logic                   out_valid_r;
  sem_pkg::out_t          out_r;

  logic [11:0]            eff_w;
  logic [15:0]            eff_h;
  logic [10:0]            col_eff;
  sem_pkg::pix_t          up_rd, mid_rd, top_px, bot_px;
  logic                   accept, cfg_wr, flush_drop, emit_cond, wrap;
  logic [11:0]            c_inc;
  logic [10:0]            x_pos;
  logic [27:0]            emit_inc;
  sem_pkg::pix_t          lft, ctr, rgt;
  logic                   out_free;

  assign eff_w = (width_r == 12'd0) ? 12'd1 :
                 (width_r > 12'(sem_pkg::MAX_WIDTH)) ? 12'(sem_pkg::MAX_WIDTH) : width_r;
  assign eff_h = (height_r == 16'd0) ? 16'd1 : height_r;
  assign col_eff = ({1'b0, col_r} < eff_w) ? col_r : 11'd0;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign flush_drop = (row_r < {1'b0, eff_h}) && in_data.flush;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == sem_pkg::REG_HEIGHT) ? {16'd0, height_r} : {20'd0, width_r};
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign out_free   = !out_valid_r || !out_stall;

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (state_r == ST_RD),
    .waddr (addr_r),
    .wdata (mid_rd),
    .raddr (col_eff),
    .rdata (up_rd)
  );

  sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (state_r == ST_RD),
    .waddr (addr_r),
    .wdata (pix_r),
    .raddr (col_eff),
    .rdata (mid_rd)
  );

  // replicate the middle row at the top and bottom borders
  assign top_px    = (row_r == 17'd1) ? mid_rd : up_rd;
  assign bot_px    = (row_r == {1'b0, eff_h}) ? mid_rd : pix_r;
  assign emit_cond = (row_r > 17'd1) || ((row_r == 17'd1) && (addr_r != '0));
  assign c_inc     = {1'b0, addr_r} + 12'd1;
  assign wrap      = (c_inc >= eff_w);
  assign x_pos     = (addr_r == '0) ? 11'(eff_w - 12'd1) : (addr_r - 11'd1);
  assign emit_inc  = emit_r + 28'd1;

  assign lft = lsel_r ? win_r[1][0] : win_r[0][0];
  assign ctr = win_r[1][0];
  assign rgt = rsel_r ? win_r[1][0] : win_r[2][0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && !flush_drop) state_nxt = ST_RD;
      ST_RD:   state_nxt = emit_cond ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ROOT;
      ST_ROOT: if (bit_r == 3'd0) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= sem_pkg::WIDTH_RST;
      height_r    <= sem_pkg::HEIGHT_RST;
      col_r       <= '0;
      row_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == ST_RD) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2][0] <= top_px;
        win_r[2][1] <= mid_rd;
        win_r[2][2] <= bot_px;
        if (emit_cond && (emit_inc >= total_r)) begin
          col_r  <= '0;
          row_r  <= '0;
          emit_r <= '0;
        end else begin
          if (emit_cond) begin
            emit_r <= emit_inc;
          end
          col_r <= wrap ? 11'd0 : c_inc[10:0];
          if (wrap) begin
            row_r <= row_r + 17'd1;
          end
        end
      end
      // register write restarts the frame
      if (cfg_wr) begin
        if (paddr[2] == sem_pkg::REG_HEIGHT) begin
          height_r <= pwdata[15:0];
        end else begin
          width_r <= pwdata[11:0];
        end
        col_r  <= '0;
        row_r  <= '0;
        emit_r <= '0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            win_r[i][j] <= '0;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic signed [23:0] sqx, sqy;
    logic [21:0]        ssum;
    logic [7:0]         t;
    logic [15:0]        tt;
    total_r <= {16'd0, eff_w} * {12'd0, eff_h};
    if (accept) begin
      addr_r <= col_eff;
      pix_r  <= (row_r < {1'b0, eff_h}) ?
                {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in} : '0;
    end
    unique case (state_r)
      ST_RD: begin
        lsel_r <= (x_pos == 11'd0);
        rsel_r <= ({1'b0, x_pos} == eff_w - 12'd1);
        last_r <= (emit_inc >= total_r);
      end
      ST_GRAD: begin
        alpha_r <= win_r[1][1][31:24];
        for (int k = 0; k < 3; k++) begin
          gx_r[k] <= $signed({4'd0, rgt[8*k +: 8]}) - $signed({4'd0, lft[8*k +: 8]})
                   + $signed({3'd0, win_r[rsel_r ? 1 : 2][1][8*k +: 8], 1'b0})
                   - $signed({3'd0, win_r[lsel_r ? 1 : 0][1][8*k +: 8], 1'b0})
                   + $signed({4'd0, win_r[rsel_r ? 1 : 2][2][8*k +: 8]})
                   - $signed({4'd0, win_r[lsel_r ? 1 : 0][2][8*k +: 8]});
          gy_r[k] <= $signed({4'd0, lft[8*k +: 8]}) + $signed({3'd0, ctr[8*k +: 8], 1'b0})
                   + $signed({4'd0, rgt[8*k +: 8]})
                   - $signed({4'd0, win_r[lsel_r ? 1 : 0][2][8*k +: 8]})
                   - $signed({3'd0, win_r[1][2][8*k +: 8], 1'b0})
                   - $signed({4'd0, win_r[rsel_r ? 1 : 2][2][8*k +: 8]});
        end
      end
      ST_SQ: begin
        for (int k = 0; k < 3; k++) begin
          sqx = gx_r[k] * gx_r[k];
          sqy = gy_r[k] * gy_r[k];
          ssum = sqx[21:0] + sqy[21:0];
          sq_r[k]   <= ssum[15:0];
          sat_r[k]  <= |ssum[21:16];
          root_r[k] <= '0;
        end
        bit_r <= 3'd7;
      end
      ST_ROOT: begin
        // try one root bit per cycle, keep it if the square still fits
        for (int k = 0; k < 3; k++) begin
          t  = root_r[k] | (8'd1 << bit_r);
          tt = t * t;
          if (tt <= sq_r[k]) begin
            root_r[k] <= t;
          end
        end
        bit_r <= bit_r - 3'd1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_r.red_edge   <= sat_r[0] ? 8'hFF : root_r[0];
          out_r.green_edge <= sat_r[1] ? 8'hFF : root_r[1];
          out_r.blue_edge  <= sat_r[2] ? 8'hFF : root_r[2];
          out_r.alpha_out  <= alpha_r;
          out_r.frame_last <= last_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/sem_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sem_chk.sv =====
// Port-level checker for the RGBA Sobel edge magnitude top level, with bind.
// Depends on sem_pkg.
module sem_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input sem_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input sem_pkg::out_t out_data,
  input logic          pready
);

  // a pixel transaction always occupies the block for the next cycle
  a_busy_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.flush) |=> in_stall)
    else $error("pixel transaction did not occupy the block");

  a_out_clear_on_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind sobel_edge_magnitude_rgba_top sem_chk u_sem_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for sobel_edge_magnitude_rgba_top: random RGBA frames
// checked against an in-bench Sobel magnitude predictor. Depends on sem_pkg.
`timescale 1ns / 100ps

module testbench;

  localparam int LINE_MAX = sem_pkg::MAX_WIDTH;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  sem_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  sem_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  sobel_edge_magnitude_rgba_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  sem_pkg::in_t  pixel_q[$];
  sem_pkg::out_t edge_q[$];
  int   errors = 0;
  bit   quiet = 1'b0;
  int   pushed = 0;

  // predictor state
  logic [11:0] img_w = 12'd640;
  logic [15:0] img_h = 16'd480;
  logic [31:0] upper_px [LINE_MAX];
  logic [31:0] middle_px [LINE_MAX];
  logic [31:0] win [3][3];
  int          col_cnt, row_cnt, done_cnt;

  function automatic void restart_frame();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    col_cnt = 0;
    row_cnt = 0;
    done_cnt = 0;
  endfunction

  function automatic void sobel_predict(sem_pkg::in_t it);
    int w, h, r, c, x, lc, rc, gx, gy, v, t;
    logic [31:0] pix, top, mid, bot, s;
    int l0, l1, l2, c0, c2, r0, r1, r2;
    logic [7:0] mag [3];
    sem_pkg::out_t res;
    w = (img_w == 0) ? 1 : (img_w > LINE_MAX) ? LINE_MAX : img_w;
    h = (img_h == 0) ? 1 : img_h;
    r = row_cnt;
    c = (col_cnt < w) ? col_cnt : 0;
    if (r < h && it.flush) return;
    pix = (r < h) ? {it.alpha_in, it.blue_in, it.green_in, it.red_in} : '0;
    top = upper_px[c];
    mid = middle_px[c];
    bot = pix;
    upper_px[c] = mid;
    middle_px[c] = pix;
    if (r == 1) top = mid;
    if (r == h) bot = mid;
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = bot;
    if (!(r > 1 || (r == 1 && c >= 1))) begin
      c++;
      if (c >= w) begin
        c = 0;
        row_cnt = r + 1;
      end
      col_cnt = c;
      return;
    end
    x = (c == 0) ? w - 1 : c - 1;
    lc = (x == 0) ? 1 : 0;
    rc = (x == w - 1) ? 1 : 2;
    for (int k = 0; k < 3; k++) begin
      l0 = win[lc][0][8*k +: 8]; l1 = win[lc][1][8*k +: 8]; l2 = win[lc][2][8*k +: 8];
      c0 = win[1][0][8*k +: 8];  c2 = win[1][2][8*k +: 8];
      r0 = win[rc][0][8*k +: 8]; r1 = win[rc][1][8*k +: 8]; r2 = win[rc][2][8*k +: 8];
      gx = -l0 + r0 - 2*l1 + 2*r1 - l2 + r2;
      gy = l0 + 2*c0 + r0 - l2 - 2*c2 - r2;
      s = gx*gx + gy*gy;
      if (s >= 65536) v = 255;
      else begin
        v = 0;
        for (int b = 7; b >= 0; b--) begin
          t = v | (1 << b);
          if (t*t <= s) v = t;
        end
      end
      mag[k] = v[7:0];
    end
    res.red_edge = mag[0];
    res.green_edge = mag[1];
    res.blue_edge = mag[2];
    res.alpha_out = win[1][1][31:24];
    done_cnt++;
    if (longint'(done_cnt) >= longint'(w) * longint'(h)) begin
      res.frame_last = 1'b1;
      col_cnt = 0;
      row_cnt = 0;
      done_cnt = 0;
    end else begin
      res.frame_last = 1'b0;
      c++;
      if (c >= w) begin
        c = 0;
        row_cnt = r + 1;
      end
      col_cnt = c;
    end
    edge_q.push_back(res);
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && !in_stall) sobel_predict(in_data);
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_data <= pixel_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int seen = 0;
  always @(posedge clk) begin
    sem_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen++;
      if (edge_q.size() == 0) begin
        $error("unexpected transaction %p", out_data);
        errors++;
      end else begin
        want = edge_q.pop_front();
        if (want.red_edge !== out_data.red_edge) begin
          $error("red_edge exp %0d got %0d", want.red_edge, out_data.red_edge);
          errors++;
        end
        if (want.green_edge !== out_data.green_edge) begin
          $error("green_edge exp %0d got %0d", want.green_edge, out_data.green_edge);
          errors++;
        end
        if (want.blue_edge !== out_data.blue_edge) begin
          $error("blue_edge exp %0d got %0d", want.blue_edge, out_data.blue_edge);
          errors++;
        end
        if (want.alpha_out !== out_data.alpha_out) begin
          $error("alpha_out exp %0d got %0d", want.alpha_out, out_data.alpha_out);
          errors++;
        end
        if (want.frame_last !== out_data.frame_last) begin
          $error("frame_last exp %0d got %0d", want.frame_last, out_data.frame_last);
          errors++;
        end
      end
    end
  end

  // receiver stall: random short stalls while not quiet, and one long hold so the block backs up into its input
  int sink_gap = 0;
  int hold_cnt = 0;
  bit held = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!held && seen >= 60) begin
      held <= 1'b1;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      sink_gap <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || edge_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == sem_pkg::REG_HEIGHT) img_h = data[15:0];
    else img_w = data[11:0];
    restart_frame();
    @(posedge clk);
  endtask

  task automatic set_size(int w, int h);
    wait_idle();
    reg_write(3'd0, w);
    reg_write(3'd4, h);
  endtask

  function automatic sem_pkg::in_t rand_pixel(bit harsh);
    sem_pkg::in_t p;
    p = '0;
    p.red_in = harsh ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
    p.green_in = harsh ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
    p.blue_in = harsh ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
    p.alpha_in = 8'($urandom);
    return p;
  endfunction

  // queue one frame: pixels (with stray flushes dropped by the block), then,
  // if all rows are queued, width+1 drain transactions, some of them plain pixels
  task automatic queue_frame(int w, int h, int rows);
    sem_pkg::in_t p;
    int ew;
    bit harsh;
    ew = (w == 0) ? 1 : (w > LINE_MAX) ? LINE_MAX : w;
    harsh = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < ew * rows; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        p = rand_pixel(1'b0);
        p.flush = 1'b1;
        pixel_q.push_back(p);
      end
      pixel_q.push_back(rand_pixel(harsh));
      pushed++;
    end
    if (rows < ((h == 0) ? 1 : h)) return;
    for (int i = 0; i <= ew; i++) begin
      p = rand_pixel(1'b0);
      p.flush = ($urandom_range(0, 7) != 0);
      pixel_q.push_back(p);
      pushed++;
    end
  endtask

  initial begin
    sem_pkg::in_t p;
    int w, h;
    restart_frame();
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_px[i] = '0;
      middle_px[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x2 frame of extremes, a stray flush, a pixel during drain
    set_size(3, 2);
    for (int i = 0; i < 6; i++) begin
      p = '0;
      p.red_in = (i % 2) ? 8'hFF : 8'h00;
      p.green_in = (i < 3) ? 8'hFF : 8'h00;
      p.blue_in = (i == 4) ? 8'hFF : 8'h00;
      p.alpha_in = (i % 3 == 0) ? 8'hFF : 8'h00;
      pixel_q.push_back(p);
      if (i == 2) begin
        p.flush = 1'b1;
        pixel_q.push_back(p);
      end
    end
    for (int i = 0; i < 4; i++) begin
      p = '1;
      p.flush = (i != 1);
      pixel_q.push_back(p);
    end
    // zero width and height act as one
    set_size(0, 0);
    queue_frame(0, 0, 1);
    // tallest frame, cut short by a register write
    set_size(3, 65535);
    queue_frame(3, 65535, 4);
    pushed = 0;

    while (pushed < 1250) begin
      if (pushed > 1100) quiet = 1'b1;
      w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      h = $urandom_range(1, 6);
      set_size(w, h);
      queue_frame(w, h, h);
    end
    quiet = 1'b1;
    wait_idle();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #30ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
